// ===== src/aapr_pkg.sv =====
// Shared constants, types and tables for the axis-angle point rotator.
package aapr_pkg;

  localparam int CoordWidthDef = 24;
  localparam int AxisWidthDef  = 16;
  localparam int AngleWidth    = 17;
  localparam int Frac          = 28;
  localparam int TrigFrac      = 30;
  localparam int CordicSteps   = 22;
  localparam int FullTurn      = 46080;
  localparam int QuarterTurn   = 11520;
  localparam int TrigWidth     = 33;
  localparam int ZWidth        = 24;
  localparam int QuadWidth     = 2;

  localparam logic signed [TrigWidth-1:0] CordicGain = 33'sd652032874;

  // Residual angle and rotation state handed from one CORDIC cell to the next
  typedef struct packed {
    logic                        vld;
    logic signed [TrigWidth-1:0] x;
    logic signed [TrigWidth-1:0] y;
    logic signed [ZWidth-1:0]    z;
    logic [QuadWidth-1:0]        quad;
  } cordic_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic signed [ZWidth-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZWidth-1:0] r;
    case (idx)
      5'd0:  r = 24'sd2949120;
      5'd1:  r = 24'sd1740967;
      5'd2:  r = 24'sd919879;
      5'd3:  r = 24'sd466945;
      5'd4:  r = 24'sd234379;
      5'd5:  r = 24'sd117304;
      5'd6:  r = 24'sd58666;
      5'd7:  r = 24'sd29335;
      5'd8:  r = 24'sd14668;
      5'd9:  r = 24'sd7334;
      5'd10: r = 24'sd3667;
      5'd11: r = 24'sd1833;
      5'd12: r = 24'sd917;
      5'd13: r = 24'sd458;
      5'd14: r = 24'sd229;
      5'd15: r = 24'sd115;
      5'd16: r = 24'sd57;
      5'd17: r = 24'sd29;
      5'd18: r = 24'sd14;
      5'd19: r = 24'sd7;
      5'd20: r = 24'sd4;
      5'd21: r = 24'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/axis_angle_point_rotate.sv =====
// Top level of the axis-angle point rotator: CORDIC chain, matrix and product stages.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  command  | start / busy         | axis_x/y/z_i, point_x/y/z_i, angle_deg_i
//  result   | done_o (one cycle)   | rot_x/y/z_o, saturated_o
//
// One transaction enters per cycle; busy is always low.
// Pipeline stages: 1 angle reduction, 22 CORDIC cells, 1 trig rounding,
// 2 matrix product stages, 1 matrix sum, 2 point product/sum stages, 1 output.
// Reset clears the chain head, the CORDIC cells and the valid flags; no results follow reset.
// The receiver cannot stall; every result is shown on done_o for one cycle.
module axis_angle_point_rotate #(
  parameter int COORD_WIDTH = aapr_pkg::CoordWidthDef,
  parameter int AXIS_WIDTH  = aapr_pkg::AxisWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [AXIS_WIDTH-1:0]        axis_x_i,
  input  logic signed [AXIS_WIDTH-1:0]        axis_y_i,
  input  logic signed [AXIS_WIDTH-1:0]        axis_z_i,
  input  logic signed [COORD_WIDTH-1:0]       point_x_i,
  input  logic signed [COORD_WIDTH-1:0]       point_y_i,
  input  logic signed [COORD_WIDTH-1:0]       point_z_i,
  input  logic signed [aapr_pkg::AngleWidth-1:0] angle_deg_i,
  output logic                                done_o,
  output logic signed [COORD_WIDTH-1:0]       rot_x_o,
  output logic signed [COORD_WIDTH-1:0]       rot_y_o,
  output logic signed [COORD_WIDTH-1:0]       rot_z_o,
  output logic                                saturated_o
);

  localparam int Steps = aapr_pkg::CordicSteps;
  localparam int TW    = aapr_pkg::TrigWidth;
  localparam int MW    = 32;   // Q.28 matrix terms, |m| < 4 for unit-ish axes
  localparam int AW    = aapr_pkg::Frac + 2; // Q.28 axis, 30 bits
  localparam int PW    = 64;
  localparam int Up    = aapr_pkg::Frac - (AXIS_WIDTH - 1);
  localparam int DataW = 3 * AXIS_WIDTH + 3 * COORD_WIDTH;
  localparam int Delay = Steps + 2;

  assign busy = 1'b0;

  // ---- stage 0: reduce angle modulo a full turn, split quadrant ----
  logic signed [aapr_pkg::AngleWidth+1:0] a0, a1, a2;
  logic [17:0] ared;
  logic [1:0]  quad;
  logic [17:0] rem;
  aapr_pkg::cordic_t head;

  always_comb begin
    a0 = (aapr_pkg::AngleWidth+2)'(angle_deg_i);
    // input lies within two turns either way
    a1 = a0[aapr_pkg::AngleWidth+1] ? a0 + 19'sd46080 : a0;
    a1 = a1[aapr_pkg::AngleWidth+1] ? a1 + 19'sd46080 : a1;
    a2 = (a1 >= 19'sd46080) ? a1 - 19'sd46080 : a1;
    ared = 18'(a2);
    if (ared >= 18'd34560) begin
      quad = 2'd3; rem = ared - 18'd34560;
    end else if (ared >= 18'd23040) begin
      quad = 2'd2; rem = ared - 18'd23040;
    end else if (ared >= 18'd11520) begin
      quad = 2'd1; rem = ared - 18'd11520;
    end else begin
      quad = 2'd0; rem = ared;
    end
  end

  // Load the chain head, clear it under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head <= '0;
    end else begin
      head.vld  <= start;
      head.x    <= aapr_pkg::CordicGain;
      head.y    <= '0;
      head.z    <= aapr_pkg::ZWidth'({rem, 9'd0});
      head.quad <= quad;
    end
  end

  // ---- CORDIC chain ----
  aapr_pkg::cordic_t chain [Steps+1];
  assign chain[0] = head;

  for (genvar g = 0; g < Steps; g++) begin : g_cell
    aapr_cordic_cell #(.Step(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  // ---- carry axis and point along ----
  logic [DataW-1:0] dat_in, dat_out;
  assign dat_in = {axis_x_i, axis_y_i, axis_z_i, point_x_i, point_y_i, point_z_i};

  aapr_delay #(.Width(DataW), .Depth(Delay)) u_delay (
    .clk_i  (clk_i),
    .data_i (dat_in),
    .data_o (dat_out)
  );

  // ---- stage T: quadrant fix-up and rounding to Q.28 ----
  logic signed [TW-1:0] cr, sr;
  logic signed [MW-1:0] c_q, s_q, cc_q;
  logic                 t_vld_q;
  aapr_pkg::cordic_t    tail;
  assign tail = chain[Steps];

  always_comb begin
    case (tail.quad)
      2'd0:    begin cr = tail.x;  sr = tail.y;  end
      2'd1:    begin cr = -tail.y; sr = tail.x;  end
      2'd2:    begin cr = -tail.x; sr = -tail.y; end
      default: begin cr = tail.y;  sr = -tail.x; end
    endcase
  end

  logic signed [TW-1:0] cr2, sr2;
  assign cr2 = (cr + TW'(2)) >>> 2;
  assign sr2 = (sr + TW'(2)) >>> 2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q <= 1'b0;
    end else begin
      t_vld_q <= tail.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q  <= MW'(cr2);
    s_q  <= MW'(sr2);
    cc_q <= MW'(33'sd268435456 - cr2);
  end

  // unpack delayed axis and point
  logic signed [AXIS_WIDTH-1:0]  ax, ay, az;
  logic signed [COORD_WIDTH-1:0] px, py, pz;
  assign {ax, ay, az, px, py, pz} = dat_out;

  logic signed [AW-1:0] u, v, w;
  assign u = AW'(ax) <<< Up;
  assign v = AW'(ay) <<< Up;
  assign w = AW'(az) <<< Up;

  function automatic logic signed [PW-1:0] rnd28(input logic signed [PW-1:0] p);
    return (p + PW'(64'sd134217728)) >>> aapr_pkg::Frac;
  endfunction

  // ---- stage M1: axis products and axis*sin ----
  logic signed [MW-1:0] uu_q, vv_q, ww_q, uv_q, uw_q, vw_q;
  logic signed [PW-1:0] us_q, vs_q, ws_q;
  logic signed [MW-1:0] c1_q, cc1_q;
  logic signed [COORD_WIDTH-1:0] px1_q, py1_q, pz1_q;
  logic                 m1_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else begin
      m1_vld_q <= t_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    uu_q  <= MW'(rnd28(PW'(u) * PW'(u)));
    vv_q  <= MW'(rnd28(PW'(v) * PW'(v)));
    ww_q  <= MW'(rnd28(PW'(w) * PW'(w)));
    uv_q  <= MW'(rnd28(PW'(u) * PW'(v)));
    uw_q  <= MW'(rnd28(PW'(u) * PW'(w)));
    vw_q  <= MW'(rnd28(PW'(v) * PW'(w)));
    us_q  <= rnd28(PW'(u) * PW'(s_q));
    vs_q  <= rnd28(PW'(v) * PW'(s_q));
    ws_q  <= rnd28(PW'(w) * PW'(s_q));
    c1_q  <= c_q;
    cc1_q <= cc_q;
    px1_q <= px;
    py1_q <= py;
    pz1_q <= pz;
  end

  // ---- stage M2: multiply by one minus cos ----
  logic signed [PW-1:0] xuu_q, xvv_q, xww_q, xuv_q, xuw_q, xvw_q;
  logic signed [PW-1:0] us2_q, vs2_q, ws2_q;
  logic signed [MW-1:0] c2_q;
  logic signed [COORD_WIDTH-1:0] px2_q, py2_q, pz2_q;
  logic                 m2_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xuu_q <= rnd28(PW'(uu_q) * PW'(cc1_q));
    xvv_q <= rnd28(PW'(vv_q) * PW'(cc1_q));
    xww_q <= rnd28(PW'(ww_q) * PW'(cc1_q));
    xuv_q <= rnd28(PW'(uv_q) * PW'(cc1_q));
    xuw_q <= rnd28(PW'(uw_q) * PW'(cc1_q));
    xvw_q <= rnd28(PW'(vw_q) * PW'(cc1_q));
    us2_q <= us_q;
    vs2_q <= vs_q;
    ws2_q <= ws_q;
    c2_q  <= c1_q;
    px2_q <= px1_q;
    py2_q <= py1_q;
    pz2_q <= pz1_q;
  end

  // ---- stage M3: assemble the nine terms ----
  localparam int TermW = 34;
  logic signed [TermW-1:0] m_q [9];
  logic signed [COORD_WIDTH-1:0] px3_q, py3_q, pz3_q;
  logic                    m3_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_vld_q <= 1'b0;
    end else begin
      m3_vld_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q[0] <= TermW'(xuu_q + PW'(c2_q));
    m_q[1] <= TermW'(xuv_q - ws2_q);
    m_q[2] <= TermW'(xuw_q + vs2_q);
    m_q[3] <= TermW'(xuv_q + ws2_q);
    m_q[4] <= TermW'(xvv_q + PW'(c2_q));
    m_q[5] <= TermW'(xvw_q - us2_q);
    m_q[6] <= TermW'(xuw_q - vs2_q);
    m_q[7] <= TermW'(xvw_q + us2_q);
    m_q[8] <= TermW'(xww_q + PW'(c2_q));
    px3_q  <= px2_q;
    py3_q  <= py2_q;
    pz3_q  <= pz2_q;
  end

  // ---- stage P1: point times term ----
  logic signed [PW-1:0] pr_q [9];
  logic                 p1_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= m3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      pr_q[3*r]   <= PW'(px3_q) * PW'(m_q[3*r]);
      pr_q[3*r+1] <= PW'(py3_q) * PW'(m_q[3*r+1]);
      pr_q[3*r+2] <= PW'(pz3_q) * PW'(m_q[3*r+2]);
    end
  end

  // ---- stage P2: sum rows and round ----
  logic signed [PW-1:0] row_q [3];
  logic                 p2_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      row_q[r] <= rnd28(pr_q[3*r] + pr_q[3*r+1] + pr_q[3*r+2]);
    end
  end

  // ---- output stage: clamp and register ----
  localparam logic signed [PW-1:0] Hi = PW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [PW-1:0] Lo = -PW'(64'sd1 <<< (COORD_WIDTH - 1));
  logic signed [COORD_WIDTH-1:0] cl [3];
  logic [2:0]                    ov;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (row_q[r] > Hi) begin
        cl[r] = COORD_WIDTH'(Hi); ov[r] = 1'b1;
      end else if (row_q[r] < Lo) begin
        cl[r] = COORD_WIDTH'(Lo); ov[r] = 1'b1;
      end else begin
        cl[r] = COORD_WIDTH'(row_q[r]); ov[r] = 1'b0;
      end
    end
  end

  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rot_x_o     <= cl[0];
    rot_y_o     <= cl[1];
    rot_z_o     <= cl[2];
    saturated_o <= |ov;
  end

  assign done_o = done_q;

endmodule

// ===== src/aapr_cordic_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation, registered.
module aapr_cordic_cell #(
  parameter int Step = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aapr_pkg::cordic_t cell_i,
  output aapr_pkg::cordic_t cell_o
);

  aapr_pkg::cordic_t cell_d, cell_q;
  logic signed [aapr_pkg::TrigWidth-1:0] xs, ys;
  logic signed [aapr_pkg::ZWidth-1:0]    ang;

  // Rotate forward while the residual is non-negative
  always_comb begin
    xs     = cell_i.x >>> Step;
    ys     = cell_i.y >>> Step;
    ang    = aapr_pkg::atan_lut(5'(Step));
    cell_d = cell_i;
    if (!cell_i.z[aapr_pkg::ZWidth-1]) begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - ang;
    end else begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + ang;
    end
  end

  // Advance the valid flag and payload, clear both under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ===== src/aapr_delay.sv =====
// Delay line that carries the axis and point alongside the CORDIC chain.
module aapr_delay #(
  parameter int Width = 8,
  parameter int Depth = 1
) (
  input  logic             clk_i,
  input  logic [Width-1:0] data_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] tap_q [Depth];

  // Shift every tap one place each cycle
  always_ff @(posedge clk_i) begin
    tap_q[0] <= data_i;
    for (int i = 1; i < Depth; i++) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign data_o = tap_q[Depth-1];

endmodule

// ===== src/aapr_checker.sv =====
// Port-level checker for the axis-angle point rotator, bound to the top level.
module aapr_checker #(
  parameter int CoordWidth = aapr_pkg::CoordWidthDef
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic signed [CoordWidth-1:0] rot_x_o,
  input logic saturated_o
);

  // Never refuse a transaction
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // Each accepted transaction yields a result on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##30 done_o)
    else $error("result missing");

  // No result without a start at the corresponding earlier cycle
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 30))
    else $error("spurious result");

  // Result value and clamp flag are known whenever a result is shown
  a_result_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown({rot_x_o, saturated_o}))
    else $error("result unknown");

endmodule

bind axis_angle_point_rotate aapr_checker #(.CoordWidth(COORD_WIDTH)) u_aapr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .rot_x_o     (rot_x_o),
  .saturated_o (saturated_o)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the axis-angle point rotator: directed table, then random points.
`timescale 1ns / 100ps

module tb_top;

  localparam int CW = aapr_pkg::CoordWidthDef;
  localparam int AW = aapr_pkg::AxisWidthDef;
  localparam int AngW = aapr_pkg::AngleWidth;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic signed [AW-1:0]         ax, ay, az;
    logic signed [CW-1:0]         px, py, pz;
    logic signed [AngW-1:0]       ang;
  } rot_cmd_t;

  typedef struct {
    logic signed [CW-1:0] rx, ry, rz;
    logic                 sat;
  } rot_res_t;

  typedef struct {
    rot_cmd_t cmd;
    bit       has_exp;
    rot_res_t exp;
  } dir_row_t;

  logic                         clk_i, rst_ni, start, busy;
  logic signed [AW-1:0]         axis_x_i, axis_y_i, axis_z_i;
  logic signed [CW-1:0]         point_x_i, point_y_i, point_z_i;
  logic signed [AngW-1:0]       angle_deg_i;
  logic                         done_o, saturated_o;
  logic signed [CW-1:0]         rot_x_o, rot_y_o, rot_z_o;

  rot_res_t rotated_q[$];
  rot_res_t typed_q[$];
  bit       typed_used_q[$];
  bit       failed;
  int       idle_cycles;

  axis_angle_point_rotate u_top (
    .clk_i, .rst_ni, .start, .busy,
    .axis_x_i, .axis_y_i, .axis_z_i,
    .point_x_i, .point_y_i, .point_z_i, .angle_deg_i,
    .done_o, .rot_x_o, .rot_y_o, .rot_z_o, .saturated_o
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint round_shift(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_shift(a * b, aapr_pkg::Frac);
  endfunction

  function automatic longint clamp_coord(longint v, ref bit sat);
    longint hi, lo;
    hi = (longint'(1) << (CW - 1)) - 1;
    lo = -(longint'(1) << (CW - 1));
    if (v > hi) begin
      v = hi;
      sat = 1'b1;
    end
    if (v < lo) begin
      v = lo;
      sat = 1'b1;
    end
    return v;
  endfunction

  // Predict the rotated point for one command
  function automatic rot_res_t rotate_point(rot_cmd_t c);
    longint atan_tab[aapr_pkg::CordicSteps] = '{2949120, 1740967, 919879, 466945, 234379,
      117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2};
    longint a, q, x, y, z, xn, co, si, cc, u, v, w, px, py, pz;
    longint m[3][3];
    bit sat;
    rot_res_t r;
    sat = 1'b0;
    a = longint'(c.ang) % aapr_pkg::FullTurn;
    if (a < 0) a += aapr_pkg::FullTurn;
    q = a / aapr_pkg::QuarterTurn;
    z = (a % aapr_pkg::QuarterTurn) * 512;
    x = longint'(aapr_pkg::CordicGain);
    y = 0;
    for (int i = 0; i < aapr_pkg::CordicSteps; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_tab[i];
      end else begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_tab[i];
      end
      x = xn;
    end
    case (q)
      0: begin co = x;  si = y;  end
      1: begin co = -y; si = x;  end
      2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
    co = round_shift(co, aapr_pkg::TrigFrac - aapr_pkg::Frac);
    si = round_shift(si, aapr_pkg::TrigFrac - aapr_pkg::Frac);
    cc = (longint'(1) << aapr_pkg::Frac) - co;
    u = longint'(c.ax) <<< (aapr_pkg::Frac - (AW - 1));
    v = longint'(c.ay) <<< (aapr_pkg::Frac - (AW - 1));
    w = longint'(c.az) <<< (aapr_pkg::Frac - (AW - 1));
    m[0][0] = qmul(qmul(u, u), cc) + co;
    m[0][1] = qmul(qmul(u, v), cc) - qmul(w, si);
    m[0][2] = qmul(qmul(u, w), cc) + qmul(v, si);
    m[1][0] = qmul(qmul(u, v), cc) + qmul(w, si);
    m[1][1] = qmul(qmul(v, v), cc) + co;
    m[1][2] = qmul(qmul(v, w), cc) - qmul(u, si);
    m[2][0] = qmul(qmul(u, w), cc) - qmul(v, si);
    m[2][1] = qmul(qmul(v, w), cc) + qmul(u, si);
    m[2][2] = qmul(qmul(w, w), cc) + co;
    px = longint'(c.px);
    py = longint'(c.py);
    pz = longint'(c.pz);
    r.rx  = CW'(clamp_coord(round_shift(px * m[0][0] + py * m[0][1] + pz * m[0][2],
                                        aapr_pkg::Frac), sat));
    r.ry  = CW'(clamp_coord(round_shift(px * m[1][0] + py * m[1][1] + pz * m[1][2],
                                        aapr_pkg::Frac), sat));
    r.rz  = CW'(clamp_coord(round_shift(px * m[2][0] + py * m[2][1] + pz * m[2][2],
                                        aapr_pkg::Frac), sat));
    r.sat = sat;
    return r;
  endfunction

  // Capture accepted transactions and check results at the rising edge
  always @(posedge clk_i) begin
    rot_cmd_t c;
    rot_res_t e;
    bit       accepted;
    accepted = 1'b0;
    if (rst_ni && start && !busy) begin
      c.ax = axis_x_i;  c.ay = axis_y_i;  c.az = axis_z_i;
      c.px = point_x_i; c.py = point_y_i; c.pz = point_z_i;
      c.ang = angle_deg_i;
      rotated_q.push_back(rotate_point(c));
      accepted = 1'b1;
    end
    if (rst_ni && done_o) begin
      accepted = 1'b1;
      if (rotated_q.size() == 0) begin
        $error("result with no transaction outstanding");
        failed = 1'b1;
      end else begin
        e = rotated_q.pop_front();
        if (typed_used_q.size() > 0 && typed_used_q.pop_front()) e = typed_q.pop_front();
        if (rot_x_o !== e.rx) begin
          $error("rot_x: expected %0d, got %0d", e.rx, rot_x_o);
          failed = 1'b1;
        end
        if (rot_y_o !== e.ry) begin
          $error("rot_y: expected %0d, got %0d", e.ry, rot_y_o);
          failed = 1'b1;
        end
        if (rot_z_o !== e.rz) begin
          $error("rot_z: expected %0d, got %0d", e.rz, rot_z_o);
          failed = 1'b1;
        end
        if (saturated_o !== e.sat) begin
          $error("saturated: expected %0d, got %0d", e.sat, saturated_o);
          failed = 1'b1;
        end
      end
    end
    // Advance the watchdog while nothing moves
    if (accepted || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // End the run on a hang
  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Drive one command and hold it until accepted
  task automatic issue_cmd(rot_cmd_t c);
    @(negedge clk_i);
    axis_x_i  = c.ax;  axis_y_i  = c.ay;  axis_z_i  = c.az;
    point_x_i = c.px;  point_y_i = c.py;  point_z_i = c.pz;
    angle_deg_i = c.ang;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_burst();
    int n;
    n = $urandom_range(14, 1);
    @(negedge clk_i);
    start = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  function automatic rot_cmd_t random_cmd();
    rot_cmd_t c;
    int pick;
    pick = $urandom_range(9);
    c.ang = AngW'($urandom_range(92159) - 46080);
    if (pick < 4) begin
      // near-unit axis along one direction, random small tilt
      c.ax = AW'($urandom_range(2000) - 1000);
      c.ay = AW'($urandom_range(2000) - 1000);
      c.az = AW'($urandom_range(2000) - 1000);
      case ($urandom_range(2))
        0: c.ax = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        1: c.ay = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        default: c.az = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      endcase
    end else if (pick < 7) begin
      // diagonal-ish axis of roughly unit length
      c.ax = AW'(($urandom_range(1) ? 1 : -1) * int'($urandom_range(19500, 18300)));
      c.ay = AW'(($urandom_range(1) ? 1 : -1) * int'($urandom_range(19500, 18300)));
      c.az = AW'(($urandom_range(1) ? 1 : -1) * int'($urandom_range(19500, 18300)));
    end else begin
      c.ax = AW'($urandom);
      c.ay = AW'($urandom);
      c.az = AW'($urandom);
    end
    if ($urandom_range(3) == 0) begin
      c.px = CW'($urandom);
      c.py = CW'($urandom);
      c.pz = CW'($urandom);
    end else begin
      c.px = CW'($urandom_range(200000) - 100000);
      c.py = CW'($urandom_range(200000) - 100000);
      c.pz = CW'($urandom_range(200000) - 100000);
    end
    return c;
  endfunction

  function automatic dir_row_t row(int ax, int ay, int az, int px, int py, int pz,
                                   int ang, bit has_exp = 0, int rx = 0, int ry = 0,
                                   int rz = 0, bit sat = 0);
    dir_row_t r;
    r.cmd.ax = AW'(ax); r.cmd.ay = AW'(ay); r.cmd.az = AW'(az);
    r.cmd.px = CW'(px); r.cmd.py = CW'(py); r.cmd.pz = CW'(pz);
    r.cmd.ang = AngW'(ang);
    r.has_exp = has_exp;
    r.exp.rx = CW'(rx); r.exp.ry = CW'(ry); r.exp.rz = CW'(rz); r.exp.sat = sat;
    return r;
  endfunction

  initial begin
    dir_row_t dir_tab[$];
    rot_cmd_t c;
    int       n_items;
    rst_ni      = 1'b0;
    start       = 1'b0;
    axis_x_i = '0; axis_y_i = '0; axis_z_i = '0;
    point_x_i = '0; point_y_i = '0; point_z_i = '0;
    angle_deg_i = '0;

    // Directed rows: zero point, each axis, quadrant boundaries, wrap and saturation
    dir_tab.push_back(row(0, 0, 32767, 0, 0, 0, 11520, 1, 0, 0, 0, 0));
    dir_tab.push_back(row(-32768, -32768, -32768, 0, 0, 0, -46080, 1, 0, 0, 0, 0));
    dir_tab.push_back(row(0, 0, 32767, 25600, 0, 0, 0));
    dir_tab.push_back(row(0, 0, 32767, 25600, 0, 0, 11520));
    dir_tab.push_back(row(0, 0, 32767, 25600, 0, 0, 23040));
    dir_tab.push_back(row(0, 0, 32767, 25600, 0, 0, 34560));
    dir_tab.push_back(row(32767, 0, 0, 0, 25600, 0, 5760));
    dir_tab.push_back(row(0, 32767, 0, 0, 0, 25600, -5760));
    dir_tab.push_back(row(0, 0, -32768, 8388607, -8388608, 0, 23040));
    dir_tab.push_back(row(0, 0, -32768, -8388608, 8388607, 8388607, 46079));
    dir_tab.push_back(row(0, 0, 32767, 1000, 2000, 3000, -46080));
    dir_tab.push_back(row(0, 0, 32767, 1000, 2000, 3000, 1));
    dir_tab.push_back(row(0, 0, 32767, 1000, 2000, 3000, -1));
    dir_tab.push_back(row(32767, 32767, 32767, 8388607, 8388607, 8388607, 4000));
    dir_tab.push_back(row(-32768, 32767, -32768, -8388608, 8388607, -8388608, -17000));
    dir_tab.push_back(row(0, 0, 0, 8388607, -8388608, 8388607, 23040));
    dir_tab.push_back(row(18919, 18919, 18919, 256, 512, -768, 15360));
    dir_tab.push_back(row(-18919, 18919, -18919, -256, 512, 768, -30720));

    // Hold reset, then release it on a falling edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      typed_used_q.push_back(dir_tab[i].has_exp);
      if (dir_tab[i].has_exp) typed_q.push_back(dir_tab[i].exp);
      issue_cmd(dir_tab[i].cmd);
    end

    // Pause until every outstanding result has arrived
    @(negedge clk_i);
    start = 1'b0;
    while (rotated_q.size() > 0) @(negedge clk_i);

    n_items = 700;
    for (int i = 0; i < n_items; i++) begin
      c = random_cmd();
      if (i < n_items - 100 && $urandom_range(5) == 0) idle_burst();
      issue_cmd(c);
    end
    @(negedge clk_i);
    start = 1'b0;

    while (rotated_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== axis_angle_point_rotate.f =====
src/aapr_pkg.sv
src/aapr_cordic_cell.sv
src/aapr_delay.sv
src/axis_angle_point_rotate.sv
src/aapr_checker.sv
test/tb_top.sv
